@@ hdl/gld_pkg.sv @@
// Shared types and constants for the GIF LZW decoder.
`default_nettype none
package gld_pkg;

  // Default sizing of the dictionary
  localparam int MAX_ENTRIES_DEF   = 4096;
  localparam int MAX_CODE_BITS_DEF = 12;

  // Code and field widths
  localparam int CODE_W = 13;
  localparam logic [CODE_W-1:0] NO_CODE = 13'h1FFF;
  localparam logic [3:0] MIN_SIZE_RESET = 4'd8;

  // Input mode codes
  localparam logic [1:0] MODE_RESTART = 2'd0;
  localparam logic [1:0] MODE_LOAD    = 2'd1;
  localparam logic [1:0] MODE_PULL    = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_RANGE = 2'd1;
  localparam logic [1:0] ERR_FIRST = 2'd2;

  // Classified operation
  typedef enum logic [1:0] {
    OP_RESTART = 2'd0,
    OP_LOAD    = 2'd1,
    OP_PULL    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // Entry of the queue between front and back
  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
  } q_item_t;

endpackage
`default_nettype wire

@@ hdl/gld_if.sv @@
// Channel interfaces: input items, results and configuration writes.
`default_nettype none
interface gld_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;
  modport source (output valid, mode, data_byte, input ready);
  modport sink (input valid, mode, data_byte, output ready);
endinterface

interface gld_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       pixel_valid;
  logic       need_byte;
  logic       accepted;
  logic [1:0] error;
  logic       stop_seen;
  modport source (output valid, pixel, pixel_valid, need_byte, accepted, error, stop_seen,
                  input ready);
  modport sink (input valid, pixel, pixel_valid, need_byte, accepted, error, stop_seen,
                output ready);
endinterface

interface gld_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

@@ hdl/gld_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none
module gld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hdl/gld_front.sv @@
// Front end: takes input transfers, classifies the mode, queues them.
`default_nettype none
module gld_front (
  input  wire logic     clk,
  input  wire logic     rst,
  gld_item_if.sink      item_in,
  output gld_pkg::q_item_t q_item,
  output logic          q_valid,
  input  wire logic     q_ready
);
  import gld_pkg::*;

  q_item_t    slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;
  op_t        op_class;

  // mode decode
  always_comb begin
    unique case (item_in.mode)
      MODE_RESTART: op_class = OP_RESTART;
      MODE_LOAD:    op_class = OP_LOAD;
      MODE_PULL:    op_class = OP_PULL;
      default:      op_class = OP_NONE;
    endcase
  end

  assign item_in.ready = (fill != 2'd2);
  assign push    = item_in.valid && item_in.ready;
  assign q_valid = (fill != 2'd0);
  assign pop     = q_valid && q_ready;
  assign q_item  = slots[rd_ptr];

  // two-entry queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= '{op: op_class, data_byte: item_in.data_byte};
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

@@ hdl/gld_core.sv @@
// Back end: bit buffer, code reader, dictionary, string stack and result register.
`default_nettype none
module gld_core #(
  parameter int MAX_ENTRIES   = gld_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_CODE_BITS = gld_pkg::MAX_CODE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire gld_pkg::q_item_t q_item,
  input  wire logic        q_valid,
  output logic             q_ready,
  gld_cfg_if.sink          cfg,
  gld_result_if.source     result_out
);
  import gld_pkg::*;

  localparam int ADDR_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = ADDR_W + 1;
  localparam logic [CODE_W-1:0] MAX_E = CODE_W'(MAX_ENTRIES);
  localparam logic [3:0] MAXB = 4'(MAX_CODE_BITS);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(MAX_ENTRIES);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_CODE = 8'b0000_0010,
    S_ADD  = 8'b0000_0100,
    S_RDI  = 8'b0000_1000,
    S_WALK = 8'b0001_0000,
    S_LIT  = 8'b0010_0000,
    S_POP  = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } st_t;

  st_t               st;
  logic [3:0]        min_size;
  logic [23:0]       bit_buf;
  logic [4:0]        bit_cnt;
  logic [3:0]        code_width;
  logic [CODE_W-1:0] next_free;
  logic [CODE_W-1:0] prev_code;
  logic [7:0]        prev_first;
  logic [CNT_W-1:0]  stack_count;
  logic [CODE_W-1:0] code;
  logic [CODE_W-1:0] walk;
  logic              stop_flag;
  logic [1:0]        err_flag;

  // result register
  logic       res_valid;
  logic [7:0] res_pix;
  logic       res_pv;
  logic       res_need;
  logic       res_acc;
  logic [1:0] res_err;
  logic       res_stop;

  // derived code values
  logic [3:0]        eff;
  logic [CODE_W-1:0] clr;
  logic [11:0]       cmask;
  logic [CODE_W-1:0] c13;
  logic [7:0]        fc;
  logic              first_lit;

  // RAM ports
  logic              dict_we;
  logic [ADDR_W-1:0] dict_waddr;
  logic [ADDR_W-1:0] dict_raddr;
  logic [7:0]        fc_wr;
  logic [CODE_W-1:0] prefix_rd;
  logic [7:0]        suffix_rd;
  logic [7:0]        first_rd;
  logic              stk_we;
  logic [ADDR_W-1:0] stk_waddr;
  logic [7:0]        stk_wdata;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_p1;
  logic [7:0]        stack_rd;

  // size clamp and code extraction
  always_comb begin
    priority if (min_size < 4'd2) eff = 4'd2;
    else if (min_size > 4'd8)     eff = 4'd8;
    else                          eff = min_size;
  end
  assign clr   = CODE_W'(13'd1 << eff);
  assign cmask = ~(12'hFFF << code_width);
  assign c13   = {1'b0, bit_buf[11:0] & cmask};
  assign cnt_m1 = stack_count - CNT_W'(1);
  assign cnt_p1 = stack_count + CNT_W'(1);

  // first code after a clear is a literal
  assign first_lit = (st == S_CODE) && (err_flag == ERR_NONE) && (stack_count == '0) &&
                     ({3'b0, bit_cnt} >= {4'b0, code_width}) && (c13 != clr) &&
                     (c13 != clr + CODE_W'(1)) && (c13 < MAX_E) && (prev_code == NO_CODE) &&
                     (c13 < clr);

  // first character of the code being added
  always_comb begin
    priority if (code < clr)   fc = code[7:0];
    else if (code == next_free) fc = prev_first;
    else                        fc = first_rd;
  end
  assign fc_wr = fc;

  // dictionary write and read addressing
  assign dict_we    = (st == S_ADD) && (next_free < MAX_E);
  assign dict_waddr = next_free[ADDR_W-1:0];
  always_comb begin
    unique case (st)
      S_WALK:  dict_raddr = prefix_rd[ADDR_W-1:0];
      S_RDI:   dict_raddr = walk[ADDR_W-1:0];
      default: dict_raddr = c13[ADDR_W-1:0];
    endcase
  end

  // stack write port
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = stack_count[ADDR_W-1:0];
    stk_wdata = walk[7:0];
    unique case (st)
      S_WALK: begin
        stk_we    = 1'b1;
        stk_wdata = suffix_rd;
      end
      S_LIT: begin
        stk_we = 1'b1;
      end
      S_CODE: begin
        stk_we    = first_lit;
        stk_waddr = '0;
        stk_wdata = c13[7:0];
      end
      default: begin
        stk_we = 1'b0;
      end
    endcase
  end

  gld_ram #(.WIDTH(CODE_W), .DEPTH(MAX_ENTRIES)) u_prefix (
    .clk(clk), .we(dict_we), .waddr(dict_waddr), .wdata(prev_code),
    .raddr(dict_raddr), .rdata(prefix_rd)
  );
  gld_ram #(.WIDTH(8), .DEPTH(MAX_ENTRIES)) u_suffix (
    .clk(clk), .we(dict_we), .waddr(dict_waddr), .wdata(fc_wr),
    .raddr(dict_raddr), .rdata(suffix_rd)
  );
  gld_ram #(.WIDTH(8), .DEPTH(MAX_ENTRIES)) u_first (
    .clk(clk), .we(dict_we), .waddr(dict_waddr), .wdata(prev_first),
    .raddr(dict_raddr), .rdata(first_rd)
  );
  gld_ram #(.WIDTH(8), .DEPTH(MAX_ENTRIES)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(cnt_m1[ADDR_W-1:0]), .rdata(stack_rd)
  );

  // handshakes
  assign q_ready   = (st == S_IDLE) && !res_valid;
  assign cfg.ready = 1'b1;
  assign result_out.valid       = res_valid;
  assign result_out.pixel       = res_pix;
  assign result_out.pixel_valid = res_pv;
  assign result_out.need_byte   = res_need;
  assign result_out.accepted    = res_acc;
  assign result_out.error       = res_err;
  assign result_out.stop_seen   = res_stop;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= S_IDLE;
      min_size    <= MIN_SIZE_RESET;
      bit_buf     <= '0;
      bit_cnt     <= '0;
      code_width  <= 4'd9;
      next_free   <= CODE_W'(258);
      prev_code   <= NO_CODE;
      stack_count <= '0;
      stop_flag   <= 1'b0;
      err_flag    <= ERR_NONE;
      res_valid   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        min_size <= cfg.data;
      end
      if (res_valid && result_out.ready) begin
        res_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            res_pix  <= '0;
            res_pv   <= 1'b0;
            res_need <= 1'b0;
            res_acc  <= 1'b0;
            st       <= S_FIN;
            unique case (q_item.op)
              OP_RESTART: begin
                stack_count <= '0;
                bit_buf     <= '0;
                bit_cnt     <= '0;
                stop_flag   <= 1'b0;
                err_flag    <= ERR_NONE;
                code_width  <= eff + 4'd1;
                next_free   <= clr + CODE_W'(2);
                prev_code   <= NO_CODE;
              end
              OP_LOAD: begin
                if ({1'b0, bit_cnt} < {2'b0, code_width}) begin
                  bit_buf <= bit_buf | (24'(q_item.data_byte) << bit_cnt);
                  bit_cnt <= bit_cnt + 5'd8;
                  res_acc <= 1'b1;
                end
              end
              OP_PULL: begin
                st <= S_CODE;
              end
              default: begin
                st <= S_FIN;
              end
            endcase
          end
        end
        S_CODE: begin
          priority if (err_flag != ERR_NONE) begin
            st <= S_FIN;
          end else if (stack_count != '0) begin
            stack_count <= cnt_m1;
            st          <= S_POP;
          end else if ({3'b0, bit_cnt} >= {4'b0, code_width}) begin
            bit_buf <= bit_buf >> code_width;
            bit_cnt <= bit_cnt - {1'b0, code_width};
            code    <= c13;
            priority if (c13 == clr) begin
              code_width <= eff + 4'd1;
              next_free  <= clr + CODE_W'(2);
              prev_code  <= NO_CODE;
            end else if (c13 == clr + CODE_W'(1)) begin
              stop_flag <= 1'b1;
            end else if (c13 >= MAX_E) begin
              err_flag <= ERR_RANGE;
            end else if (prev_code == NO_CODE) begin
              if (c13 >= clr) begin
                err_flag <= ERR_FIRST;
              end else begin
                prev_code   <= c13;
                prev_first  <= c13[7:0];
                stack_count <= CNT_W'(1);
              end
            end else if ((next_free < MAX_E) && (c13 > next_free)) begin
              err_flag <= ERR_RANGE;
            end else begin
              st <= S_ADD;
            end
          end else begin
            res_need <= 1'b1;
            st       <= S_FIN;
          end
        end
        S_ADD: begin
          if (next_free < MAX_E) begin
            next_free <= next_free + CODE_W'(1);
            if ((next_free + CODE_W'(1) == (CODE_W'(1) << code_width)) &&
                (code_width < MAXB)) begin
              code_width <= code_width + 4'd1;
            end
          end
          prev_code  <= code;
          prev_first <= fc;
          walk       <= code;
          st         <= (code < clr) ? S_LIT : S_RDI;
        end
        S_RDI: begin
          st <= S_WALK;
        end
        S_WALK: begin
          stack_count <= cnt_p1;
          walk        <= prefix_rd;
          priority if (cnt_p1 == DEPTH_C) st <= S_CODE;
          else if (prefix_rd < clr)       st <= S_LIT;
          else                            st <= S_WALK;
        end
        S_LIT: begin
          stack_count <= cnt_p1;
          st          <= S_CODE;
        end
        S_POP: begin
          res_pix <= stack_rd;
          res_pv  <= 1'b1;
          st      <= S_FIN;
        end
        S_FIN: begin
          res_valid <= 1'b1;
          res_err   <= err_flag;
          res_stop  <= stop_flag;
          st        <= S_IDLE;
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  // stack never grows past its depth
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stack_count <= DEPTH_C) else $error("string stack overflow");

  // code width stays within the legal range
  a_width_range: assert property (@(posedge clk) disable iff (rst)
    code_width >= 4'd3 && code_width <= MAXB) else $error("code width out of range");

  // a result never carries a pixel and a byte request at once
  a_pix_need: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_pv && res_need)) else $error("pixel and need_byte together");

  // buffer never holds more bits than a refused load allows
  a_bits_bound: assert property (@(posedge clk) disable iff (rst)
    bit_cnt <= 5'd19) else $error("bit buffer overfilled");
endmodule
`default_nettype wire

@@ hdl/gif_lzw_decoder_unit.sv @@
// Top level of the GIF LZW decoder: front queue plus decode back end.
//
// Channels: item_in carries mode and data_byte (restart, load one byte, pull one
// pixel); result_out returns exactly one result per item, in order; cfg writes
// min_code_size and is always ready (write only while the block is idle).
// Restart, load and unused mode go to the finish state, which raises the result.
// A pull that finds no whole code passes the code state first, and a pull served
// from the string stack passes the code and pop states. A pull that must decode
// reads a clear, stop or first code in the code state; any other code read from
// the bit buffer goes on to the add state, then for a non-literal code to a first
// dictionary read and a walk of its string through the dictionary RAMs, then to
// the literal state. The walk uses the prefix/suffix RAM read port.
// One item is in the back end at a time; a new item starts once the previous
// result has been taken. A two-entry queue keeps taking input meanwhile.
// Reset (synchronous, active high) empties the queue, clears the bit buffer,
// flags and stack, sets min_code_size to 8 and starts a fresh dictionary; the
// dictionary and stack RAMs are not cleared.
// When the receiver stalls, the result holds and the queue fills, then stalls.
`default_nettype none
module gif_lzw_decoder_unit #(
  parameter int MAX_ENTRIES   = gld_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_CODE_BITS = gld_pkg::MAX_CODE_BITS_DEF
) (
  input wire logic     clk,
  input wire logic     rst,
  gld_item_if.sink     item_in,
  gld_result_if.source result_out,
  gld_cfg_if.sink      cfg
);
  import gld_pkg::*;

  q_item_t q_item;
  logic    q_valid;
  logic    q_ready;

  gld_front u_front (
    .clk(clk), .rst(rst), .item_in(item_in),
    .q_item(q_item), .q_valid(q_valid), .q_ready(q_ready)
  );

  gld_core #(.MAX_ENTRIES(MAX_ENTRIES), .MAX_CODE_BITS(MAX_CODE_BITS)) u_core (
    .clk(clk), .rst(rst), .q_item(q_item), .q_valid(q_valid), .q_ready(q_ready),
    .cfg(cfg), .result_out(result_out)
  );
endmodule
`default_nettype wire

@@ tb/sv/gif_lzw_decoder_unit_tb.sv @@
// Testbench for the GIF LZW decoder: directed table, encoded random streams, scoreboard.
module gif_lzw_decoder_unit_tb;
  import gld_pkg::*;

  localparam int DICT_SIZE = 4096;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int IDLE_PAUSE = 40;

  typedef struct packed {
    logic [7:0] pixel;
    logic       pixel_valid;
    logic       need_byte;
    logic       accepted;
    logic [1:0] error;
    logic       stop_seen;
  } px_result_t;

  typedef struct {
    logic [1:0] mode;
    logic [7:0] dat;
    bit         typed;
    px_result_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gld_item_if   item_bus ();
  gld_result_if res_bus ();
  gld_cfg_if    cfg_bus ();

  gif_lzw_decoder_unit dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_bus),
    .result_out (res_bus),
    .cfg        (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decoder shadow state
  logic [12:0] dict_prefix [DICT_SIZE];
  logic [7:0]  dict_suffix [DICT_SIZE];
  logic [7:0]  dict_first  [DICT_SIZE];
  logic [7:0]  pix_stack   [DICT_SIZE];
  int unsigned stack_depth;
  logic [23:0] bit_buf;
  int unsigned bits_held;
  int unsigned code_w;
  int unsigned free_code;
  logic [12:0] prev_code;
  logic        stop_hit;
  logic [1:0]  err_state;
  logic [3:0]  size_reg;

  px_result_t pending_px [$];
  int unsigned fail_count = 0;
  bit rx_idle_on = 1'b1;

  function automatic int unsigned lit_bits();
    int unsigned m;
    m = size_reg;
    if (m < 2) m = 2;
    if (m > 8) m = 8;
    return m;
  endfunction

  function automatic void dict_restart();
    code_w = lit_bits() + 1;
    free_code = (1 << lit_bits()) + 2;
    prev_code = NO_CODE;
  endfunction

  function automatic logic [7:0] lead_char(int unsigned c);
    if (c < (1 << lit_bits())) return c[7:0];
    return dict_first[c % DICT_SIZE];
  endfunction

  // One data code: add an entry and walk its string onto the stack
  function automatic logic [1:0] take_code(int unsigned c);
    int unsigned clr;
    int unsigned walk;
    int unsigned e;
    clr = 1 << lit_bits();
    if (c >= DICT_SIZE) return ERR_RANGE;
    if (prev_code == NO_CODE) begin
      if (c >= clr) return ERR_FIRST;
      prev_code = c[12:0];
      pix_stack[0] = c[7:0];
      stack_depth = 1;
      return ERR_NONE;
    end
    if (free_code < DICT_SIZE) begin
      if (c > free_code) return ERR_RANGE;
      e = free_code;
      dict_suffix[e] = lead_char(c == free_code ? prev_code : c);
      dict_prefix[e] = prev_code;
      dict_first[e] = lead_char(prev_code);
      free_code++;
      if (free_code == (1 << code_w) && code_w < 12) code_w++;
    end
    prev_code = c[12:0];
    stack_depth = 0;
    walk = c;
    while (stack_depth < DICT_SIZE) begin
      if (walk < clr) begin
        pix_stack[stack_depth++] = walk[7:0];
        break;
      end
      pix_stack[stack_depth++] = dict_suffix[walk % DICT_SIZE];
      walk = dict_prefix[walk % DICT_SIZE];
    end
    return ERR_NONE;
  endfunction

  function automatic px_result_t decode_step(logic [1:0] m, logic [7:0] b);
    px_result_t r;
    int unsigned c;
    int unsigned clr;
    r = '0;
    if (m == MODE_RESTART) begin
      stack_depth = 0;
      bit_buf = '0;
      bits_held = 0;
      stop_hit = 1'b0;
      err_state = ERR_NONE;
      dict_restart();
    end else if (m == MODE_LOAD) begin
      if (bits_held < code_w) begin
        bit_buf = bit_buf | (24'(b) << bits_held);
        bits_held += 8;
        r.accepted = 1'b1;
      end
    end else if (m == MODE_PULL && err_state == ERR_NONE) begin
      while (stack_depth == 0 && err_state == ERR_NONE && bits_held >= code_w) begin
        c = bit_buf & ((1 << code_w) - 1);
        clr = 1 << lit_bits();
        bit_buf = bit_buf >> code_w;
        bits_held -= code_w;
        if (c == clr) dict_restart();
        else if (c == clr + 1) stop_hit = 1'b1;
        else err_state = take_code(c);
      end
      if (err_state == ERR_NONE) begin
        if (stack_depth > 0) begin
          stack_depth--;
          r.pixel = pix_stack[stack_depth];
          r.pixel_valid = 1'b1;
        end else begin
          r.need_byte = 1'b1;
        end
      end
    end
    r.error = err_state;
    r.stop_seen = stop_hit;
    return r;
  endfunction

  // Stream encoder side: mirrors code width and dictionary growth
  logic [7:0]  enc_bytes [$];
  logic [31:0] enc_acc;
  int unsigned enc_nbits;
  int unsigned enc_w;
  int unsigned enc_free;
  bit          enc_fresh;
  bit          stream_broken;
  bit          literal_bias;

  function automatic void enc_restart();
    enc_bytes.delete();
    enc_acc = '0;
    enc_nbits = 0;
    enc_w = lit_bits() + 1;
    enc_free = (1 << lit_bits()) + 2;
    enc_fresh = 1'b1;
    stream_broken = 1'b0;
  endfunction

  function automatic void enc_emit();
    int unsigned clr;
    int unsigned c;
    int unsigned r;
    int unsigned hi;
    clr = 1 << lit_bits();
    hi = (enc_free < DICT_SIZE) ? enc_free : DICT_SIZE - 1;
    r = $urandom_range(0, 99);
    if (enc_fresh) c = (r < 8) ? clr : $urandom_range(0, clr - 1);
    else if (literal_bias && r < 90) c = $urandom_range(0, clr - 1);
    else if (r < 3) c = clr;
    else if (r < 5) c = clr + 1;
    else if (r < 20 && enc_free < DICT_SIZE) c = enc_free;
    else if (r < 50) c = $urandom_range(hi > 12 ? hi - 12 : 0, hi);
    else c = $urandom_range(0, hi);
    enc_acc = enc_acc | (c << enc_nbits);
    enc_nbits += enc_w;
    while (enc_nbits >= 8) begin
      enc_bytes.push_back(enc_acc[7:0]);
      enc_acc = enc_acc >> 8;
      enc_nbits -= 8;
    end
    if (c == clr) begin
      enc_w = lit_bits() + 1;
      enc_free = clr + 2;
      enc_fresh = 1'b1;
    end else if (c != clr + 1) begin
      if (enc_fresh) enc_fresh = 1'b0;
      else if (enc_free < DICT_SIZE) begin
        enc_free++;
        if (enc_free == (1 << enc_w) && enc_w < 12) enc_w++;
      end
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(string what, px_result_t got, px_result_t want);
    fail_count++;
    $display("mismatch %s: got %p expected %p", what, got, want);
  endtask

  // Result side: random stalls and scoreboard
  int unsigned rx_stall;
  px_result_t  rx_got;
  px_result_t  rx_want;
  always @(posedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
      rx_stall <= 0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        rx_got = '{res_bus.pixel, res_bus.pixel_valid, res_bus.need_byte,
                   res_bus.accepted, res_bus.error, res_bus.stop_seen};
        if (pending_px.size() == 0) begin
          report_mismatch("unexpected result", rx_got, '0);
        end else begin
          rx_want = pending_px.pop_front();
          if (rx_got.pixel !== rx_want.pixel) report_mismatch("pixel", rx_got, rx_want);
          if (rx_got.pixel_valid !== rx_want.pixel_valid)
            report_mismatch("pixel_valid", rx_got, rx_want);
          if (rx_got.need_byte !== rx_want.need_byte)
            report_mismatch("need_byte", rx_got, rx_want);
          if (rx_got.accepted !== rx_want.accepted)
            report_mismatch("accepted", rx_got, rx_want);
          if (rx_got.error !== rx_want.error) report_mismatch("error", rx_got, rx_want);
          if (rx_got.stop_seen !== rx_want.stop_seen)
            report_mismatch("stop_seen", rx_got, rx_want);
        end
      end
      if (rx_stall > 0) begin
        rx_stall <= rx_stall - 1;
        res_bus.ready <= 1'b0;
      end else if (!rx_idle_on || $urandom_range(0, 9) < 7) begin
        res_bus.ready <= 1'b1;
      end else begin
        res_bus.ready <= 1'b0;
        rx_stall <= pick_gap();
      end
    end
  end

  // Watchdog on cycles without any transfer
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if ((item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  bit tx_idle_on = 1'b1;

  // Send one item, predict its result, wait for the transfer
  task automatic send_item(logic [1:0] m, logic [7:0] b, bit typed, px_result_t typed_res);
    int unsigned gap;
    px_result_t r;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    r = decode_step(m, b);
    pending_px.push_back(typed ? typed_res : r);
    item_bus.valid <= 1'b1;
    item_bus.mode <= m;
    item_bus.data_byte <= b;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    item_bus.valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  task automatic write_size(logic [3:0] v);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data <= v;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    size_reg = v;
  endtask

  // One random item, chosen from the decoder shadow state
  task automatic random_item();
    logic [1:0] m;
    logic [7:0] b;
    px_result_t r;
    int unsigned gap;
    if (stream_broken || err_state != ERR_NONE) begin
      if ($urandom_range(0, 7) == 0) begin
        send_item(MODE_RESTART, 8'($urandom), 1'b0, '0);
        enc_restart();
      end else begin
        send_item(2'($urandom_range(1, 3)), 8'($urandom), 1'b0, '0);
      end
    end else if ($urandom_range(0, 39) == 0) begin
      m = 2'($urandom_range(0, 3));
      if (m == MODE_PULL) m = 2'(OP_NONE);
      send_item(m, 8'($urandom), 1'b0, '0);
      if (m == MODE_RESTART) enc_restart();
      if (m == MODE_LOAD) stream_broken = 1'b1;
    end else if ((stack_depth > 0 || bits_held >= code_w) && $urandom_range(0, 19) != 0) begin
      send_item(MODE_PULL, 8'($urandom), 1'b0, '0);
    end else begin
      while (enc_bytes.size() == 0) enc_emit();
      // inline send so that a refused byte stays queued
      gap = tx_idle_on ? pick_gap() : 0;
      if (gap > 0) begin
        item_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      b = enc_bytes[0];
      r = decode_step(MODE_LOAD, b);
      if (r.accepted) void'(enc_bytes.pop_front());
      pending_px.push_back(r);
      item_bus.valid <= 1'b1;
      item_bus.mode <= MODE_LOAD;
      item_bus.data_byte <= b;
      @(posedge clk);
      while (!item_bus.ready) @(posedge clk);
    end
  endtask

  stim_row_t directed [25];
  logic [3:0] phase_sizes [8] = '{4'd2, 4'd8, 4'd5, 4'd0, 4'd15, 4'd3, 4'd7, 4'd2};

  initial begin
    // Directed rows at the reset size of 8: refused load, first-code error,
    // stop code, code past the next free entry, unused mode
    directed = '{
      '{MODE_PULL,    8'h00, 1, '{8'h00, 0, 1, 0, ERR_NONE, 0}},
      '{2'(OP_NONE),  8'hFF, 1, '{8'h00, 0, 0, 0, ERR_NONE, 0}},
      '{MODE_LOAD,    8'h00, 1, '{8'h00, 0, 0, 1, ERR_NONE, 0}},
      '{MODE_LOAD,    8'h00, 1, '{8'h00, 0, 0, 1, ERR_NONE, 0}},
      '{MODE_LOAD,    8'hFF, 1, '{8'h00, 0, 0, 0, ERR_NONE, 0}},
      '{MODE_PULL,    8'h00, 1, '{8'h00, 1, 0, 0, ERR_NONE, 0}},
      '{MODE_PULL,    8'hFF, 1, '{8'h00, 0, 1, 0, ERR_NONE, 0}},
      '{MODE_RESTART, 8'h00, 1, '{8'h00, 0, 0, 0, ERR_NONE, 0}},
      '{MODE_LOAD,    8'h02, 1, '{8'h00, 0, 0, 1, ERR_NONE, 0}},
      '{MODE_LOAD,    8'h01, 1, '{8'h00, 0, 0, 1, ERR_NONE, 0}},
      '{MODE_PULL,    8'h00, 1, '{8'h00, 0, 0, 0, ERR_FIRST, 0}},
      '{MODE_PULL,    8'h00, 1, '{8'h00, 0, 0, 0, ERR_FIRST, 0}},
      '{MODE_LOAD,    8'hFF, 1, '{8'h00, 0, 0, 1, ERR_FIRST, 0}},
      '{MODE_RESTART, 8'hFF, 1, '{8'h00, 0, 0, 0, ERR_NONE, 0}},
      '{MODE_LOAD,    8'h01, 1, '{8'h00, 0, 0, 1, ERR_NONE, 0}},
      '{MODE_LOAD,    8'h01, 1, '{8'h00, 0, 0, 1, ERR_NONE, 0}},
      '{MODE_PULL,    8'h00, 1, '{8'h00, 0, 1, 0, ERR_NONE, 1}},
      '{MODE_PULL,    8'h00, 1, '{8'h00, 0, 1, 0, ERR_NONE, 1}},
      '{MODE_RESTART, 8'h00, 1, '{8'h00, 0, 0, 0, ERR_NONE, 0}},
      '{MODE_LOAD,    8'h41, 1, '{8'h00, 0, 0, 1, ERR_NONE, 0}},
      '{MODE_LOAD,    8'h58, 1, '{8'h00, 0, 0, 1, ERR_NONE, 0}},
      '{MODE_PULL,    8'h00, 1, '{8'h41, 1, 0, 0, ERR_NONE, 0}},
      '{MODE_LOAD,    8'h02, 1, '{8'h00, 0, 0, 1, ERR_NONE, 0}},
      '{MODE_PULL,    8'h00, 1, '{8'h00, 0, 0, 0, ERR_RANGE, 0}},
      '{MODE_RESTART, 8'h00, 0, '{8'h00, 0, 0, 0, ERR_NONE, 0}}
    };

    item_bus.valid = 1'b0;
    item_bus.mode = MODE_RESTART;
    item_bus.data_byte = 8'h00;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = MIN_SIZE_RESET;

    // Shadow reset
    size_reg = MIN_SIZE_RESET;
    stack_depth = 0;
    bit_buf = '0;
    bits_held = 0;
    stop_hit = 1'b0;
    err_state = ERR_NONE;
    dict_restart();
    literal_bias = 1'b0;
    enc_restart();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send_item(directed[i].mode, directed[i].dat, directed[i].typed, directed[i].res);

    // Random phases, each at a new size; the last one favors literal codes
    foreach (phase_sizes[p]) begin
      wait_drained();
      write_size(phase_sizes[p]);
      tx_idle_on = (p % 3) != 1;
      rx_idle_on = (p % 4) != 2;
      literal_bias = (p == 7);
      send_item(MODE_RESTART, 8'h00, 1'b0, '0);
      enc_restart();
      for (int n = 0; n < 170; n++) begin
        random_item();
        // sender holds off until every result is back
        if (n == 85) wait_drained();
      end
    end

    item_bus.valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/gld_pkg.sv
hdl/gld_if.sv
hdl/gld_ram.sv
hdl/gld_front.sv
hdl/gld_core.sv
hdl/gif_lzw_decoder_unit.sv
tb/sv/gif_lzw_decoder_unit_tb.sv
